// ===== src/ripple_splash_table_macros.svh =====
// Assertion macros for the ripple splash table checker.
// Included by the checker file only.
`ifndef RIPPLE_SPLASH_TABLE_MACROS_SVH
`define RIPPLE_SPLASH_TABLE_MACROS_SVH

// same-cycle implication, quiet during reset
`define RST_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, quiet during reset
`define RST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/rsplash_pkg.sv =====
// Shared types and constants for the ripple splash table.
// No dependencies; used by the top level and its checker.
`timescale 1ns / 1ps
`default_nettype none
package rsplash_pkg;

  localparam int unsigned DEF_MAX_ENTRIES   = 40;
  localparam int unsigned DEF_TICKS_PER_SEC = 40;
  localparam int unsigned CLOCK_SPAN_SEC    = 600;

  localparam logic [30:0] HEIGHT_MAX = 31'h7FFF_FFFF;
  localparam logic [30:0] FADE_LIMIT = 31'd33;
  localparam logic [23:0] FT_CAP     = 24'd262144;
  localparam logic [16:0] LEVEL_MAX  = 17'd65536;
  localparam logic [30:0] RESET_UNIT = 31'd65536;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_FRAME = 2'd1,
    OP_CLEAR = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_REF_DISTANCE  = 2'd0,
    CFG_POOL_MODE     = 2'd1,
    CFG_SPLASH_RADIUS = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic        [30:0] radius;
    logic        [30:0] height;
    logic signed [31:0] x1;
    logic signed [31:0] y1;
    logic signed [31:0] x2;
    logic signed [31:0] y2;
  } entry_t;

  typedef enum logic [5:0] {
    S_IDLE, S_ADD_RD, S_ADD_A, S_ADD_B, S_ADD_C, S_ADD_D, S_ADD_E, S_MERGE_W,
    S_APPEND, S_SCAN_RD, S_SCAN_CMP, S_SCAN_END, S_SHIFT_RD, S_SHIFT_W, S_APP_W,
    S_EXP1, S_EXP2, S_DIVE, S_EXP3, S_FR_RD, S_FR_A, S_FR_W,
    S_SC1, S_SC2, S_SC3, S_DIV1, S_SC4, S_SC5, S_SC6, S_DIV2, S_SC7,
    S_RD_WAIT, S_RD_OUT, S_DONE
  } state_t;

endpackage
`default_nettype wire

// ===== src/ripple_splash_table.sv =====
// Ripple splash table: entry memory, sequencer, shared multiplier and divider.
// Depends on rsplash_pkg.
//
//   channel | signals                          | transfer when
//   config  | cfg_we, cfg_idx, cfg_data        | cfg_we high
//   input   | in_valid, in_stall, op .. slot   | in_valid and not in_stall
//   output  | out_valid, out_stall, entry_*..  | out_valid and not out_stall
//
// One item at a time. An add that merges into an entry of nonzero radius runs
// two 64-step divides; a plain append needs none, and a full table adds a scan
// for the lowest entry. A frame runs the same two divides per live entry (none
// when its new radius is zero) on the one-bit-per-cycle divider.
// rst is synchronous and empties the table; the tick clock restarts at zero.
// A held result stalls the final write-out, and with it the next transfer.
`timescale 1ns / 1ps
`default_nettype none
module ripple_splash_table #(
  parameter int unsigned MAX_ENTRIES   = rsplash_pkg::DEF_MAX_ENTRIES,
  parameter int unsigned TICKS_PER_SEC = rsplash_pkg::DEF_TICKS_PER_SEC
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_idx,
  input  logic [30:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         op,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic [30:0]        add_height,
  input  logic signed [31:0] box_x1,
  input  logic signed [31:0] box_y1,
  input  logic signed [31:0] box_x2,
  input  logic signed [31:0] box_y2,
  input  logic [23:0]        frame_ticks,
  input  logic [5:0]         slot,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               entry_valid,
  output logic signed [31:0] entry_x,
  output logic signed [31:0] entry_y,
  output logic [30:0]        entry_radius,
  output logic [16:0]        entry_level,
  output logic signed [31:0] out_x1,
  output logic signed [31:0] out_y1,
  output logic signed [31:0] out_x2,
  output logic signed [31:0] out_y2,
  output logic [5:0]         entry_count,
  output logic [30:0]        elapsed_ticks
);
  import rsplash_pkg::*;

  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam logic [AW-1:0] LAST = AW'(MAX_ENTRIES - 1);
  localparam logic [CW-1:0] FULL = CW'(MAX_ENTRIES);
  localparam logic [47:0] CLK_LIM =
    48'(longint'(CLOCK_SPAN_SEC) * longint'(TICKS_PER_SEC) * 64'd65536);
  localparam int EXP_SH = 31 + $clog2(TICKS_PER_SEC);
  localparam logic [32:0] EXP_RCP =
    33'(((64'd1 << EXP_SH) + 64'(TICKS_PER_SEC) - 64'd1) / 64'(TICKS_PER_SEC));

  state_t state, state_next;

  logic [30:0] ref_distance, splash_radius;
  logic        pool_mode;

  logic [CW-1:0] count;
  logic [30:0]   clock;

  op_t                op_q;
  logic signed [31:0] px, py, bx1, by1, bx2, by2;
  logic [30:0]        ah;

  entry_t        mem [MAX_ENTRIES];
  entry_t        rd, cur, mem_wd;
  logic [AW-1:0] ra, mem_wa;
  logic          mem_we;

  logic [32:0] mul_a;
  logic [31:0] mul_b;
  logic [64:0] prod;
  logic [63:0] dvd, d2;
  logic [31:0] dvs, e;
  logic [32:0] rem;
  logic [5:0]  cnt;
  logic [30:0] sh, num, sq, minh, ay_q;
  logic        far, hit;
  logic [CW-1:0] idx, keep;
  logic [AW-1:0] low;

  logic        accept, out_free, div_last, near, merge, pass;
  logic signed [32:0] dx, dy;
  logic [32:0] ax, ay, rem_sh, rsum, q3;
  logic        ge;
  logic [30:0] rn, qsat, pool_h, msum_sat;
  logic [31:0] csum, msum;
  logic [32:0] tcap;
  logic [33:0] psum;
  logic [CW-1:0] keep_n, cm1;
  entry_t      new_ent;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign div_last = (cnt == 6'd63);
  assign cm1      = count - CW'(1);

  always_comb begin
    dx = 33'(px) - 33'(rd.x);
    dy = 33'(py) - 33'(rd.y);
    ax = dx[32] ? 33'(-dx) : 33'(dx);
    ay = dy[32] ? 33'(-dy) : 33'(dy);
    near = !far && (d2[63:60] == 4'd0) && ({d2[59:0], 4'd0} < prod[63:0]);
    merge = near && ({1'b0, cur.radius} < {splash_radius, 1'b0});
    rem_sh = {rem[31:0], dvd[63]};
    ge = (rem_sh >= {1'b0, dvs});
    rsum = {2'b0, rd.radius} + {1'b0, e};
    rn = (rsum > {2'b0, HEIGHT_MAX}) ? HEIGHT_MAX : rsum[30:0];
    tcap = (dvd > 64'h1_0000_0000) ? 33'h1_0000_0000 : dvd[32:0];
    qsat = (dvd > {33'd0, HEIGHT_MAX}) ? HEIGHT_MAX : dvd[30:0];
    q3 = {1'b0, qsat, 1'b0} + {2'b0, qsat};
    psum = {3'b0, cur.height} + {1'b0, q3};
    pool_h = psum[32:2];
    msum = {1'b0, cur.height} + {1'b0, sq};
    msum_sat = msum[31] ? HEIGHT_MAX : msum[30:0];
    csum = {1'b0, clock} + {8'd0, frame_ticks};
    pass = (sq >= FADE_LIMIT);
    keep_n = keep + CW'(pass);
    new_ent = '{x: px, y: py, radius: splash_radius, height: ah,
                x1: bx1, y1: by1, x2: bx2, y2: by2};
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = ra;
    mem_wd = new_ent;
    unique case (state)
      S_MERGE_W: begin
        mem_we = 1'b1;
        mem_wa = cm1[AW-1:0];
        mem_wd = cur;
        mem_wd.height = msum_sat;
        if (bx1 < cur.x1) mem_wd.x1 = bx1;
        if (by1 < cur.y1) mem_wd.y1 = by1;
        if (bx2 > cur.x2) mem_wd.x2 = bx2;
        if (by2 > cur.y2) mem_wd.y2 = by2;
      end
      S_APPEND: begin
        mem_we = (count < FULL);
        mem_wa = count[AW-1:0];
      end
      S_APP_W: begin
        mem_we = 1'b1;
        mem_wa = LAST;
      end
      S_SHIFT_W: begin
        mem_we = 1'b1;
        mem_wa = idx[AW-1:0];
        mem_wd = rd;
      end
      S_FR_W: begin
        mem_we = pass;
        mem_wa = keep[AW-1:0];
        mem_wd = cur;
        mem_wd.height = sq;
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd <= mem[ra];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (op_t'(op))
            OP_ADD:   state_next = (count != '0) ? S_ADD_RD : S_APPEND;
            OP_FRAME: state_next = (count != '0) ? S_EXP1 : S_DONE;
            OP_CLEAR: state_next = S_DONE;
            OP_READ:  state_next = ({1'b0, slot} < 7'(count)) ? S_RD_WAIT : S_DONE;
            default:  state_next = S_DONE;
          endcase
        end
      end
      S_ADD_RD:   state_next = S_ADD_A;
      S_ADD_A:    state_next = S_ADD_B;
      S_ADD_B:    state_next = S_ADD_C;
      S_ADD_C:    state_next = S_ADD_D;
      S_ADD_D:    state_next = S_ADD_E;
      S_ADD_E: begin
        if (!merge) state_next = S_APPEND;
        else if (cur.radius == '0) state_next = S_MERGE_W;
        else state_next = S_SC1;
      end
      S_MERGE_W:  state_next = S_DONE;
      S_APPEND:   state_next = (count < FULL) ? S_DONE : S_SCAN_RD;
      S_SCAN_RD:  state_next = S_SCAN_CMP;
      S_SCAN_CMP: state_next = (idx[AW-1:0] == LAST) ? S_SCAN_END : S_SCAN_RD;
      S_SCAN_END: begin
        if (ah < minh) state_next = S_DONE;
        else if (low == LAST) state_next = S_APP_W;
        else state_next = S_SHIFT_RD;
      end
      S_SHIFT_RD: state_next = S_SHIFT_W;
      S_SHIFT_W:  state_next = (idx + CW'(1) == CW'(LAST)) ? S_APP_W : S_SHIFT_RD;
      S_APP_W:    state_next = S_DONE;
      S_EXP1:     state_next = S_EXP2;
      S_EXP2:     state_next = S_DIVE;
      S_DIVE:     state_next = S_EXP3;
      S_EXP3:     state_next = S_FR_RD;
      S_FR_RD:    state_next = S_FR_A;
      S_FR_A:     state_next = (rn == '0) ? S_FR_W : S_SC1;
      S_FR_W:     state_next = (idx + CW'(1) == count) ? S_DONE : S_FR_RD;
      S_SC1:      state_next = S_SC2;
      S_SC2:      state_next = S_SC3;
      S_SC3:      state_next = S_DIV1;
      S_DIV1:     state_next = div_last ? S_SC4 : S_DIV1;
      S_SC4:      state_next = S_SC5;
      S_SC5:      state_next = S_SC6;
      S_SC6:      state_next = S_DIV2;
      S_DIV2:     state_next = div_last ? S_SC7 : S_DIV2;
      S_SC7:      state_next = (op_q == OP_ADD) ? S_MERGE_W : S_FR_W;
      S_RD_WAIT:  state_next = S_RD_OUT;
      S_RD_OUT:   state_next = S_DONE;
      S_DONE:     state_next = out_free ? S_IDLE : S_DONE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_distance  <= RESET_UNIT;
      splash_radius <= RESET_UNIT;
      pool_mode     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_REF_DISTANCE:  ref_distance  <= cfg_data;
        CFG_POOL_MODE:     pool_mode     <= cfg_data[0];
        CFG_SPLASH_RADIUS: splash_radius <= cfg_data;
        default:           pool_mode     <= pool_mode;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (state)
      S_DIV1, S_DIV2: begin
        rem <= ge ? (rem_sh - {1'b0, dvs}) : rem_sh;
        dvd <= {dvd[62:0], ge};
        cnt <= cnt + 6'd1;
      end
      default: cnt <= '0;
    endcase
    case (state)
      S_IDLE: begin
        if (accept) begin
          op_q <= op_t'(op);
          px   <= pos_x;
          py   <= pos_y;
          ah   <= add_height;
          bx1  <= box_x1;
          by1  <= box_y1;
          bx2  <= box_x2;
          by2  <= box_y2;
          hit  <= 1'b0;
          ra   <= (op_t'(op) == OP_READ) ? slot[AW-1:0] : cm1[AW-1:0];
          mul_a <= {2'b0, ref_distance};
          mul_b <= (frame_ticks < FT_CAP) ? {8'd0, frame_ticks} : {8'd0, FT_CAP};
        end
      end
      S_ADD_A: begin
        cur   <= rd;
        far   <= (ax[32:31] != 2'd0) || (ay[32:31] != 2'd0);
        ay_q  <= ay[30:0];
        mul_a <= {2'b0, ax[30:0]};
        mul_b <= {1'b0, ax[30:0]};
      end
      S_ADD_B: begin
        mul_a <= {2'b0, ay_q};
        mul_b <= {1'b0, ay_q};
      end
      S_ADD_C: begin
        d2    <= prod[63:0];
        mul_a <= {2'b0, splash_radius};
        mul_b <= {1'b0, splash_radius};
      end
      S_ADD_D: d2 <= d2 + prod[63:0];
      S_ADD_E: begin
        sh  <= ah;
        num <= splash_radius;
        dvs <= {1'b0, cur.radius};
        sq  <= (ah == '0) ? '0 : HEIGHT_MAX;
      end
      S_APPEND: begin
        ra  <= '0;
        idx <= '0;
      end
      S_SCAN_CMP: begin
        if (idx == '0 || rd.height < minh) begin
          minh <= rd.height;
          low  <= idx[AW-1:0];
        end
        idx <= idx + CW'(1);
        ra  <= AW'(idx + CW'(1));
      end
      S_SCAN_END: begin
        idx <= CW'(low);
        ra  <= low + AW'(1);
      end
      S_SHIFT_W: begin
        idx <= idx + CW'(1);
        ra  <= AW'(idx + CW'(2));
      end
      S_EXP2: begin
        mul_a <= EXP_RCP;
        mul_b <= {1'b0, prod[48:18]};
      end
      S_EXP3: begin
        e    <= 32'(prod >> EXP_SH);
        idx  <= '0;
        keep <= '0;
        ra   <= '0;
      end
      S_FR_A: begin
        cur <= {rd.x, rd.y, rn, rd.height, rd.x1, rd.y1, rd.x2, rd.y2};
        num <= rd.radius;
        sh  <= rd.height;
        dvs <= {1'b0, rn};
        sq  <= rd.height;
      end
      S_FR_W: begin
        keep <= keep_n;
        idx  <= idx + CW'(1);
        ra   <= AW'(idx + CW'(1));
      end
      S_SC1: begin
        mul_a <= {2'b0, sh};
        mul_b <= {1'b0, num};
      end
      S_SC3: begin
        dvd <= prod[63:0];
        rem <= '0;
      end
      S_SC4: begin
        mul_a <= tcap;
        mul_b <= {1'b0, num};
      end
      S_SC6: begin
        dvd <= prod[63:0];
        rem <= '0;
      end
      S_SC7: sq <= (op_q == OP_FRAME && pool_mode) ? pool_h : qsat;
      S_RD_OUT: begin
        cur <= rd;
        hit <= 1'b1;
      end
      default: far <= far;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      clock <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept && op_t'(op) == OP_CLEAR) begin
            count <= '0;
          end
          if (accept && op_t'(op) == OP_FRAME && count != '0) begin
            clock <= (48'(csum) > CLK_LIM) ? '0 : csum[30:0];
          end
        end
        S_APPEND: begin
          if (count < FULL) count <= count + CW'(1);
        end
        S_FR_W: begin
          if (idx + CW'(1) == count) count <= keep_n;
        end
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      entry_valid   <= hit;
      entry_x       <= hit ? cur.x : '0;
      entry_y       <= hit ? cur.y : '0;
      entry_radius  <= hit ? cur.radius : '0;
      entry_level   <= !hit ? '0 :
                       (cur.height > 31'(LEVEL_MAX)) ? LEVEL_MAX : cur.height[16:0];
      out_x1        <= hit ? cur.x1 : '0;
      out_y1        <= hit ? cur.y1 : '0;
      out_x2        <= hit ? cur.x2 : '0;
      out_y2        <= hit ? cur.y2 : '0;
      entry_count   <= 6'(count);
      elapsed_ticks <= clock;
    end
  end

endmodule
`default_nettype wire

// ===== src/rsplash_checker.sv =====
// Port-level checks for the ripple splash table, bound to the top level.
// Depends on rsplash_pkg and ripple_splash_table_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "ripple_splash_table_macros.svh"
module rsplash_checker #(
  parameter int unsigned MAX_ENTRIES = rsplash_pkg::DEF_MAX_ENTRIES
) (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               entry_valid,
  input wire logic signed [31:0] entry_x,
  input wire logic [30:0]        entry_radius,
  input wire logic [16:0]        entry_level,
  input wire logic [5:0]         entry_count
);
  import rsplash_pkg::*;

  `RST_ASSERT_NEXT(a_busy_after_transfer, in_valid && !in_stall, in_stall, "took two items back to back")
  `RST_ASSERT_NOW(a_invalid_is_zero, out_valid && !entry_valid, entry_x == '0 && entry_radius == '0 && entry_level == '0, "invalid entry fields not zero")
  `RST_ASSERT_NOW(a_level_clamped, out_valid, entry_level <= LEVEL_MAX, "level above one")
  `RST_ASSERT_NOW(a_hit_needs_entries, out_valid && entry_valid, entry_count != 6'd0 || MAX_ENTRIES == 64, "read hit on empty table")

endmodule

bind ripple_splash_table rsplash_checker #(.MAX_ENTRIES(MAX_ENTRIES)) u_rsplash_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .entry_valid  (entry_valid),
  .entry_x      (entry_x),
  .entry_radius (entry_radius),
  .entry_level  (entry_level),
  .entry_count  (entry_count)
);
`default_nettype wire
